FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files. Every macro samples on the rising
// edge of clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every sampled edge.
`define BHPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// The condition must never be true at a sampled edge.
`define BHPQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BHPQ_ASSERT(label, prop, msg)
`define BHPQ_ASSERT_NEVER(label, cond, msg)
`endif
`endif

FILE: src/bhpq_pkg.sv
package bhpq_pkg;

  // Heap geometry.
  localparam int CAPACITY  = 256;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int COUNT_W   = 9;
  localparam int CHILD_W   = ADDR_W + 2;

  // Depth of the request queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [KEY_WIDTH-1:0] key_t;

  // Input command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Operation the back end carries out for a classified request.
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REJECT = 2'd2
  } op_e;

  typedef struct packed {
    logic command;
    key_t key;
  } in_item_t;

  typedef struct packed {
    key_t             popped_key;
    key_t             top_key;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]       status;
  } out_item_t;

  // Classified request: the count is the fill level after the operation.
  typedef struct packed {
    op_e                op;
    logic [1:0]         status;
    key_t               key;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  // True when key a is served strictly before key b.
  function automatic logic precedes(key_t a, key_t b, logic smallest_first);
    return smallest_first ? (a < b) : (a > b);
  endfunction

endpackage

FILE: src/bhpq_ram.sv
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

FILE: src/bhpq_front.sv
module bhpq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bhpq_pkg::in_item_t in_item_i,
  output logic               q_push_o,
  output bhpq_pkg::cmd_t     q_cmd_o,
  input  logic               q_full_i
);
  import bhpq_pkg::*;

  logic [COUNT_W-1:0] count_d, count_q;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  // Classify the request against the fill level it will find.
  always_comb begin
    q_cmd_o.key    = in_item_i.key;
    q_cmd_o.count  = count_q;
    q_cmd_o.status = STATUS_DONE;
    q_cmd_o.op     = OP_REJECT;
    if (in_item_i.command == CMD_PUSH) begin
      if (count_q == COUNT_W'(CAPACITY)) begin
        q_cmd_o.status = STATUS_FULL;
      end else begin
        q_cmd_o.op    = OP_PUSH;
        q_cmd_o.count = count_q + 1'b1;
      end
    end else begin
      if (count_q == '0) begin
        q_cmd_o.status = STATUS_EMPTY;
      end else begin
        q_cmd_o.op    = OP_POP;
        q_cmd_o.count = count_q - 1'b1;
      end
    end
  end

  assign count_d = q_push_o ? q_cmd_o.count : count_q;

  // Fill level as seen by accepted requests.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

FILE: src/bhpq_cmd_fifo.sv
`include "assert_macros.svh"

module bhpq_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bhpq_pkg::cmd_t wdata_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output bhpq_pkg::cmd_t rdata_o
);
  import bhpq_pkg::*;

  cmd_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_d, cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = entries_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

  `BHPQ_ASSERT_NEVER(a_no_overflow, push_i && full_o, "request queue written while full")
  `BHPQ_ASSERT_NEVER(a_no_underflow, pop_i && !valid_o, "request queue read while empty")

endmodule

FILE: src/bhpq_engine.sv
`include "assert_macros.svh"

module bhpq_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                order_mode_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  bhpq_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bhpq_pkg::out_item_t out_item_o
);
  import bhpq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LAST  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_CMP   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e             state_d, state_q;
  logic [ADDR_W-1:0]  pos_d, pos_q;
  key_t               key_d, key_q;
  key_t               popped_d, popped_q;
  key_t               root_q;
  logic [COUNT_W-1:0] n_d, n_q;
  logic [1:0]         status_d, status_q;
  logic               down_d, down_q;
  logic               out_valid_q;
  out_item_t          out_item_q;
  logic               out_load;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, raddr_a, raddr_b;
  key_t               ram_wdata, rdata_a, rdata_b;

  logic [ADDR_W-1:0]  parent;
  logic [CHILD_W-1:0] left, right, n_ext;
  logic [COUNT_W-1:0] pos_cnt;
  logic               take_left, take_right;
  key_t               mid_key;

  bhpq_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // Neighbors of the current position in the heap.
  assign parent  = ADDR_W'((pos_q - 1'b1) >> 1);
  assign left    = CHILD_W'({pos_q, 1'b1});
  assign right   = left + 1'b1;
  assign n_ext   = CHILD_W'(n_q);
  assign pos_cnt = COUNT_W'(pos_q);

  // Child selection for one level of sift-down.
  assign take_left  = (left < n_ext) && !precedes(key_q, rdata_a, order_mode_i);
  assign mid_key    = take_left ? rdata_a : key_q;
  assign take_right = (right < n_ext) && !precedes(mid_key, rdata_b, order_mode_i);

  assign cmd_ready_o = (state_q == ST_IDLE);

  // Sequencer: each level passes through a fetch state and a compare-and-write state.
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    key_d     = key_q;
    n_d       = n_q;
    down_d    = down_q;
    status_d  = status_q;
    popped_d  = popped_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = key_q;
    raddr_a   = parent;
    raddr_b   = right[ADDR_W-1:0];
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // Fetch the last entry early in case this is a pop.
        raddr_a = cmd_i.count[ADDR_W-1:0];
        if (cmd_valid_i) begin
          key_d    = cmd_i.key;
          n_d      = cmd_i.count;
          status_d = cmd_i.status;
          popped_d = '0;
          unique case (cmd_i.op)
            OP_PUSH: begin
              pos_d   = ADDR_W'(cmd_i.count - 1'b1);
              down_d  = 1'b0;
              state_d = ST_FETCH;
            end
            OP_POP: begin
              popped_d = root_q;
              pos_d    = '0;
              down_d   = 1'b1;
              state_d  = (cmd_i.count == '0) ? ST_DONE : ST_LAST;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_LAST: begin
        // The former last entry becomes the key that sinks from the root.
        key_d   = rdata_a;
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (down_q) begin
          raddr_a = left[ADDR_W-1:0];
          state_d = ST_CMP;
        end else if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        ram_we = 1'b1;
        if (down_q) begin
          if (take_right) begin
            ram_wdata = rdata_b;
            pos_d     = right[ADDR_W-1:0];
            state_d   = ST_FETCH;
          end else if (take_left) begin
            ram_wdata = rdata_a;
            pos_d     = left[ADDR_W-1:0];
            state_d   = ST_FETCH;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          if (precedes(rdata_a, key_q, order_mode_i)) begin
            state_d = ST_DONE;
          end else begin
            ram_wdata = rdata_a;
            pos_d     = parent;
            state_d   = ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers, the root copy and the result register.
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    key_q    <= key_d;
    n_q      <= n_d;
    down_q   <= down_d;
    status_q <= status_d;
    popped_q <= popped_d;
    if (ram_we && (ram_waddr == '0)) begin
      root_q <= ram_wdata;
    end
    if (out_load) begin
      out_item_q.popped_key  <= popped_q;
      out_item_q.top_key     <= (n_q != '0) ? root_q : '0;
      out_item_q.entry_count <= n_q;
      out_item_q.status      <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `BHPQ_ASSERT(a_up_not_root, (state_q == ST_CMP) && !down_q |-> pos_q != '0, "sift-up compare at root")
  `BHPQ_ASSERT(a_down_in_heap, (state_q == ST_FETCH) && down_q |-> pos_cnt < n_q, "sift-down outside heap")
  `BHPQ_ASSERT(a_take_leaves_idle, cmd_valid_i && cmd_ready_o |=> state_q != ST_IDLE, "request lost")

endmodule

FILE: src/binary_heap_priority_queue.sv
// Binary heap priority queue of signed 32-bit keys, up to 256 entries. Each
// request (push a key or pop the top entry) yields exactly one result with the
// popped key, the key now on top, the entry count and a status: a pop on an
// empty heap or a push on a full heap is flagged and leaves the heap alone.
// The order register selects largest-first (0, reset) or smallest-first (1);
// write it only while no request is in flight. Each level that a key moves
// costs a registered read of the heap memory and then a compare-and-write,
// and a pop first fetches the last entry; a rejected request or a pop that
// leaves the heap empty goes straight to its result. A two-entry request
// queue and a result register let requests be accepted while a result waits
// to be taken.
module binary_heap_priority_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bhpq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bhpq_pkg::out_item_t out_item_o
);
  import bhpq_pkg::*;

  logic order_q;
  logic q_push, q_full, q_valid, q_pop;
  cmd_t q_wcmd, q_rcmd;

  // Order register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  bhpq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_push_o   (q_push),
    .q_cmd_o    (q_wcmd),
    .q_full_i   (q_full)
  );

  bhpq_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wcmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rdata_o (q_rcmd)
  );

  logic eng_ready;

  assign q_pop = q_valid && eng_ready;

  bhpq_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .order_mode_i (order_q),
    .cmd_valid_i  (q_valid),
    .cmd_ready_o  (eng_ready),
    .cmd_i        (q_rcmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

FILE: tb/binary_heap_priority_queue_tb.sv
`timescale 1ns / 100ps

module binary_heap_priority_queue_tb;
  import bhpq_pkg::*;

  localparam key_t KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};
  localparam key_t KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  localparam int   MAX_PRINTED = 100;

  // One row of the directed table. Rows with has_typed set carry their result.
  typedef struct packed {
    logic      command;
    key_t      key;
    logic      has_typed;
    out_item_t typed;
  } step_row_t;

  localparam int DIRECTED_ROWS = 21;
  localparam step_row_t DIRECTED[0:DIRECTED_ROWS-1] = '{
    '{CMD_POP,  32'sd0,        1'b1, '{32'sd0,  32'sd0,  9'd0, STATUS_EMPTY}},
    '{CMD_PUSH, KEY_MAX,       1'b1, '{32'sd0,  KEY_MAX, 9'd1, STATUS_DONE}},
    '{CMD_PUSH, KEY_MIN,       1'b1, '{32'sd0,  KEY_MAX, 9'd2, STATUS_DONE}},
    '{CMD_POP,  32'sd0,        1'b1, '{KEY_MAX, KEY_MIN, 9'd1, STATUS_DONE}},
    '{CMD_POP,  KEY_MAX,       1'b1, '{KEY_MIN, 32'sd0,  9'd0, STATUS_DONE}},
    '{CMD_POP,  KEY_MIN,       1'b1, '{32'sd0,  32'sd0,  9'd0, STATUS_EMPTY}},
    '{CMD_PUSH, 32'sd0,        1'b1, '{32'sd0,  32'sd0,  9'd1, STATUS_DONE}},
    '{CMD_PUSH, -32'sd1,       1'b1, '{32'sd0,  32'sd0,  9'd2, STATUS_DONE}},
    '{CMD_PUSH, 32'sd1,        1'b1, '{32'sd0,  32'sd1,  9'd3, STATUS_DONE}},
    '{CMD_PUSH, 32'sd1,        1'b0, '0},
    '{CMD_PUSH, -32'sd1,       1'b0, '0},
    '{CMD_PUSH, 32'h5555_5555, 1'b0, '0},
    '{CMD_PUSH, 32'hAAAA_AAAA, 1'b0, '0},
    '{CMD_POP,  32'sd0,        1'b0, '0},
    '{CMD_POP,  32'sd0,        1'b0, '0},
    '{CMD_POP,  32'sd0,        1'b0, '0},
    '{CMD_POP,  32'sd0,        1'b0, '0},
    '{CMD_POP,  32'sd0,        1'b0, '0},
    '{CMD_POP,  32'sd0,        1'b0, '0},
    '{CMD_POP,  32'sd0,        1'b0, '0},
    '{CMD_POP,  32'sd0,        1'b1, '{32'sd0,  32'sd0,  9'd0, STATUS_EMPTY}}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // Shadow heap: same layout and same sift steps as the block.
  key_t        shadow_keys [CAPACITY];
  int unsigned shadow_fill = 0;
  logic        shadow_smallest = 1'b0;

  out_item_t   expected_results[$];
  int          error_count = 0;
  int unsigned result_index = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          ready_hold_left = 0;

  binary_heap_priority_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // True when key a leaves the heap strictly ahead of key b.
  function automatic bit served_ahead(key_t a, key_t b);
    return shadow_smallest ? (a < b) : (a > b);
  endfunction

  function automatic void swap_keys(int i, int j);
    key_t held;
    held = shadow_keys[i];
    shadow_keys[i] = shadow_keys[j];
    shadow_keys[j] = held;
  endfunction

  // Apply one request to the shadow heap and return the result it yields.
  function automatic out_item_t apply_heap_request(in_item_t req);
    out_item_t res;
    int        pos;
    int        parent;
    int        best;
    int        left;
    res = '0;
    res.status = STATUS_DONE;
    if (req.command == CMD_PUSH) begin
      if (shadow_fill >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        pos = shadow_fill;
        shadow_keys[pos] = req.key;
        shadow_fill++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (served_ahead(shadow_keys[parent], shadow_keys[pos])) break;
          swap_keys(parent, pos);
          pos = parent;
        end
      end
    end else begin
      if (shadow_fill == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.popped_key = shadow_keys[0];
        shadow_fill--;
        shadow_keys[0] = shadow_keys[shadow_fill];
        pos = 0;
        forever begin
          best = pos;
          left = 2 * pos + 1;
          if (left < shadow_fill && !served_ahead(shadow_keys[best], shadow_keys[left]))
            best = left;
          if (left + 1 < shadow_fill &&
              !served_ahead(shadow_keys[best], shadow_keys[left + 1]))
            best = left + 1;
          if (best == pos) break;
          swap_keys(pos, best);
          pos = best;
        end
      end
    end
    res.top_key = (shadow_fill > 0) ? shadow_keys[0] : '0;
    res.entry_count = COUNT_W'(shadow_fill);
    return res;
  endfunction

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("result %0d: %s got %0h, expected %0h", result_index, what, got, want);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, top_key", 64'(got.top_key), 64'd0);
    end else begin
      want = expected_results.pop_front();
      if (got.popped_key !== want.popped_key)
        report_mismatch("popped_key", 64'(got.popped_key), 64'(want.popped_key));
      if (got.top_key !== want.top_key)
        report_mismatch("top_key", 64'(got.top_key), 64'(want.top_key));
      if (got.entry_count !== want.entry_count)
        report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
    end
    result_index++;
  endtask

  // Result side: check every accepted result, then pick the next ready value.
  // A long hold-off requested by the stimulus is counted down here.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_item_o);
    if (ready_hold_left > 0) begin
      out_ready_i <= 1'b0;
      ready_hold_left = ready_hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request, wait for it to be taken, and record its result.
  task automatic send_request(in_item_t req, logic has_typed, out_item_t typed);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_heap_request(req);
    expected_results.push_back(has_typed ? typed : predicted);
  endtask

  function automatic key_t random_key();
    case ($urandom_range(9))
      0: return KEY_MAX;
      1: return KEY_MIN;
      2: return '0;
      3: return -1;
      4, 5: return key_t'($urandom_range(15)) - 8;
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic send_random(logic command);
    in_item_t req;
    req.command = command;
    req.key     = random_key();
    send_request(req, 1'b0, '0);
  endtask

  task automatic run_random(int count, int push_pct);
    for (int n = 0; n < count; n++)
      send_random(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP);
  endtask

  // Let every outstanding request finish so the block is idle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_order(logic smallest_first);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= smallest_first;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_smallest = smallest_first;
  endtask

  initial begin
    in_item_t req;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, largest first.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      req.command = DIRECTED[r].command;
      req.key     = DIRECTED[r].key;
      send_request(req, DIRECTED[r].has_typed, DIRECTED[r].typed);
    end

    // Random phases under different idling, flipping the order with keys held.
    run_random(80, 60);
    wait_idle();
    write_order(1'b1);
    send_idle_pct = 51;
    run_random(80, 50);
    wait_idle();
    write_order(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    run_random(80, 45);
    wait_idle();
    write_order(1'b1);
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    run_random(80, 55);
    wait_idle();
    write_order(1'b0);

    // Fill to capacity while the result side holds off, push into the full
    // heap, then drain it and pop past empty.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    ready_hold_left = 400;
    while (shadow_fill < CAPACITY) send_random(CMD_PUSH);
    repeat (6) send_random(CMD_PUSH);
    recv_stall_pct = 29;
    while (shadow_fill > 0) send_random(CMD_POP);
    repeat (4) send_random(CMD_POP);

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("binary_heap_priority_queue_tb: clean");
    end else begin
      $display("binary_heap_priority_queue_tb: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("binary_heap_priority_queue_tb: errors");
    $finish;
  end

endmodule
